// File: hdl/pps_pkg.sv
// Shared types, constants and helpers for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

	localparam int MaxProcs = 16;
	localparam int IDX_W    = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
	localparam int CNT_W    = $clog2(MaxProcs + 1);
	localparam int TIME_W   = 20;
	localparam int BURST_W  = 16;
	localparam int PRIO_W   = 8;
	localparam int OIDX_W   = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_CALC,
		ST_WB
	} state_t;

	typedef struct packed {
		logic               req_type;
		logic [TIME_W-1:0]  arrival_time;
		logic [BURST_W-1:0] burst_length;
		logic [PRIO_W-1:0]  prio_level;
	} req_t;

	typedef struct packed {
		logic              busy_res;
		logic [OIDX_W-1:0] process_index;
		logic              segment_start;
		logic [TIME_W-1:0] tick_start;
		logic              first_dispatch;
		logic [TIME_W-1:0] response_time;
		logic              finished;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [TIME_W-1:0] waiting_time;
		logic              all_done;
	} res_t;

	typedef struct packed {
		logic [TIME_W-1:0]  arrival;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
		logic [BURST_W-1:0] remaining;
	} entry_t;

	// Running winner of the priority scan
	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [PRIO_W-1:0] prio;
	} pick_t;

	// Low bits of a table index for the result field
	function automatic logic [OIDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
		logic [IDX_W+OIDX_W-1:0] w;
		w = {{OIDX_W{1'b0}}, idx};
		return w[OIDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: hdl/pps_req_if.sv
// Request channel: valid/ready handshake carrying one scheduler request.
`default_nettype none
interface pps_req_if;
	logic          valid;
	logic          ready;
	pps_pkg::req_t req;

	modport source (output valid, output req, input ready);
	modport sink (input valid, input req, output ready);
endinterface
`default_nettype wire

// File: hdl/pps_res_if.sv
// Result channel: valid/ready handshake carrying one tick result.
`default_nettype none
interface pps_res_if;
	logic          valid;
	logic          ready;
	pps_pkg::res_t res;

	modport source (output valid, output res, input ready);
	modport sink (input valid, input res, output ready);
endinterface
`default_nettype wire

// File: hdl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: sequencer, flags, counters, result register.
// Load request: taken in idle, no result; a load into a full table is dropped.
// Tick request: scan (one read and compare per cycle over the loaded entries), then fetch,
//   arithmetic, write-back; the next request is taken only after the sequencer returns to idle.
// The result is registered at write-back; it is held while the next request is taken, and only
//   a result still waiting at write-back stalls the sequencer.
// Reset (arst_n low, async) clears counters, time, flags and result valid, not table payload.
`default_nettype none
module preemptive_priority_scheduler (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pps_req_if.sink    req_ch,
	pps_res_if.source  res_ch
);

	localparam int IDX_W   = pps_pkg::IDX_W;
	localparam int CNT_W   = pps_pkg::CNT_W;
	localparam int TIME_W  = pps_pkg::TIME_W;
	localparam int BURST_W = pps_pkg::BURST_W;

	pps_pkg::state_t state_q, state_d;

	// table bookkeeping
	logic [CNT_W-1:0]            loaded_q;
	logic [CNT_W-1:0]            completed_q;
	logic [pps_pkg::MaxProcs-1:0] done_q;
	logic [pps_pkg::MaxProcs-1:0] started_q;

	// time and chart tracking
	logic [TIME_W-1:0] time_q;
	logic [TIME_W-1:0] after_q;
	logic              prev_none_q;
	logic              prev_busy_q;
	logic [IDX_W-1:0]  prev_idx_q;

	// scan sequencer
	logic [CNT_W-1:0] scan_q;
	logic             cmp_v_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// arithmetic results for the picked entry
	logic [TIME_W-1:0] resp_q;
	logic [TIME_W-1:0] tat_q;

	// output register
	pps_pkg::res_t res_q;
	logic          res_v_q;

	// memory and compare unit hookup
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	pps_pkg::entry_t  mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	pps_pkg::entry_t  mem_rdata;
	pps_pkg::pick_t   pick;

	logic req_acc, load_acc, tick_acc, full, issue, wb_go;

	// write-back datapath
	logic [BURST_W-1:0] rem_n;
	logic               fin;
	logic               first;
	logic               seg;
	logic [CNT_W-1:0]   completed_n;
	logic [TIME_W-1:0]  burst_ext;
	pps_pkg::res_t      res_d;

	assign req_ch.ready = (state_q == pps_pkg::ST_IDLE);
	assign req_acc      = req_ch.valid && req_ch.ready;
	assign load_acc     = req_acc && (req_ch.req.req_type == pps_pkg::REQ_LOAD);
	assign tick_acc     = req_acc && (req_ch.req.req_type == pps_pkg::REQ_TICK);
	assign full         = (loaded_q == CNT_W'(pps_pkg::MaxProcs));
	assign issue        = (state_q == pps_pkg::ST_SCAN) && (scan_q < loaded_q);
	// write-back waits for room in the output register
	assign wb_go        = (state_q == pps_pkg::ST_WB) && (!res_v_q || res_ch.ready);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pps_pkg::ST_IDLE: begin
				if (tick_acc) begin
					state_d = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				// last compare lands on the edge that leaves this state
				if (!issue) begin
					state_d = pps_pkg::ST_FETCH;
				end
			end
			pps_pkg::ST_FETCH: state_d = pps_pkg::ST_CALC;
			pps_pkg::ST_CALC:  state_d = pps_pkg::ST_WB;
			pps_pkg::ST_WB: begin
				if (wb_go) begin
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default: state_d = pps_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Table memory: loads write a new row, write-back rewrites the winner
	// ---------------------------------------------------------------
	always_comb begin
		mem_raddr = issue ? scan_q[IDX_W-1:0] : pick.idx;
		mem_we    = 1'b0;
		mem_waddr = pick.idx;
		mem_wdata = mem_rdata;
		mem_wdata.remaining = rem_n;
		if (load_acc && !full) begin
			mem_we              = 1'b1;
			mem_waddr           = loaded_q[IDX_W-1:0];
			mem_wdata.arrival   = req_ch.req.arrival_time;
			mem_wdata.burst     = req_ch.req.burst_length;
			mem_wdata.prio      = req_ch.req.prio_level;
			mem_wdata.remaining = req_ch.req.burst_length;
		end else if (wb_go && pick.found) begin
			mem_we = 1'b1;
		end
	end

	pps_table u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// read data comes back in the cycle after the address: tag it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q[IDX_W-1:0];
	end

	pps_pick u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (tick_acc),
		.cmp_v    (cmp_v_s1),
		.cmp_idx  (cmp_idx_s1),
		.ent      (mem_rdata),
		.ent_done (done_q[cmp_idx_s1]),
		.now      (time_q),
		.pick     (pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (tick_acc) begin
			scan_q <= '0;
		end else if (issue) begin
			scan_q <= scan_q + CNT_W'(1);
		end
	end

	// ---------------------------------------------------------------
	// Arithmetic: after-time at accept, response/turnaround in CALC
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			after_q <= (time_q == pps_pkg::TIME_MAX) ? time_q : time_q + TIME_W'(1);
		end
		if (state_q == pps_pkg::ST_CALC) begin
			resp_q <= time_q - mem_rdata.arrival;
			tat_q  <= after_q - mem_rdata.arrival;
		end
	end

	// ---------------------------------------------------------------
	// Write-back: remaining burst, finish, chart segment, result
	// ---------------------------------------------------------------
	assign rem_n       = mem_rdata.remaining - BURST_W'(mem_rdata.remaining != '0);
	assign fin         = pick.found && (rem_n == '0);
	assign first       = pick.found && !started_q[pick.idx];
	assign completed_n = completed_q + CNT_W'(fin);
	assign burst_ext   = TIME_W'(mem_rdata.burst);
	// chart segment opens on first tick, busy/idle change, or a new runner
	assign seg = prev_none_q || (prev_busy_q != pick.found) ||
	             (pick.found && (prev_idx_q != pick.idx));

	always_comb begin
		res_d                 = '0;
		res_d.busy_res        = pick.found;
		res_d.process_index   = pick.found ? pps_pkg::idx_to_out(pick.idx) : '0;
		res_d.segment_start   = seg;
		res_d.tick_start      = time_q;
		res_d.first_dispatch  = first;
		res_d.response_time   = first ? resp_q : '0;
		res_d.finished        = fin;
		res_d.completion_time = fin ? after_q : '0;
		res_d.turnaround_time = fin ? tat_q : '0;
		// saturated time can leave turnaround below the burst: floor at zero
		res_d.waiting_time    = (fin && (tat_q > burst_ext)) ? tat_q - burst_ext : '0;
		res_d.all_done        = (completed_n >= loaded_q);
	end

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= '0;
			completed_q <= '0;
			done_q      <= '0;
			started_q   <= '0;
			time_q      <= '0;
			prev_none_q <= 1'b1;
			prev_busy_q <= 1'b0;
			prev_idx_q  <= '0;
		end else begin
			if (load_acc && !full) begin
				loaded_q <= loaded_q + CNT_W'(1);
				done_q[loaded_q[IDX_W-1:0]]    <= (req_ch.req.burst_length == '0);
				started_q[loaded_q[IDX_W-1:0]] <= 1'b0;
				// a zero burst is finished on arrival
				completed_q <= completed_q +
				               CNT_W'(req_ch.req.burst_length == '0);
			end
			if (wb_go) begin
				time_q      <= after_q;
				completed_q <= completed_n;
				prev_none_q <= 1'b0;
				prev_busy_q <= pick.found;
				prev_idx_q  <= pick.idx;
				if (pick.found) begin
					started_q[pick.idx] <= 1'b1;
					if (fin) begin
						done_q[pick.idx] <= 1'b1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (wb_go) begin
			res_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			res_q <= res_d;
		end
	end

	assign res_ch.valid = res_v_q;
	assign res_ch.res   = res_q;

`ifndef SYNTH
	a_completed_le_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		completed_q <= loaded_q)
		else $error("completed count above loaded count");

	a_result_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(state_q == pps_pkg::ST_WB))
		else $error("result raised outside write-back");

	a_winner_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pps_pkg::ST_WB && pick.found) |-> !done_q[pick.idx])
		else $error("finished entry picked to run");

	a_time_only_on_wb: assert property (@(posedge clk) disable iff (!arst_n)
		!wb_go |=> $stable(time_q))
		else $error("time moved outside write-back");
`endif

endmodule
`default_nettype wire

// File: hdl/pps_table.sv
// Process table memory: one write port, one read port with registered data.
`default_nettype none
module pps_table (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [pps_pkg::IDX_W-1:0]    waddr,
	input  wire pps_pkg::entry_t              wdata,
	input  wire logic [pps_pkg::IDX_W-1:0]    raddr,
	output pps_pkg::entry_t                   rdata
);

	pps_pkg::entry_t mem_q [pps_pkg::MaxProcs];
	pps_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hdl/pps_pick.sv
// Shared compare unit: keeps the best ready entry seen during a scan.
`default_nettype none
module pps_pick (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         cmp_v,
	input  wire logic [pps_pkg::IDX_W-1:0]    cmp_idx,
	input  wire pps_pkg::entry_t              ent,
	input  wire logic                         ent_done,
	input  wire logic [pps_pkg::TIME_W-1:0]   now,
	output pps_pkg::pick_t                    pick
);

	logic                         found_q;
	logic [pps_pkg::IDX_W-1:0]    idx_q;
	logic [pps_pkg::PRIO_W-1:0]   prio_q;
	logic                         better;

	// strict less-than keeps the lowest index on equal priority
	assign better = cmp_v && !ent_done && (ent.arrival <= now) &&
	                (!found_q || (ent.prio < prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!clear && better) begin
			idx_q  <= cmp_idx;
			prio_q <= ent.prio;
		end
	end

	assign pick.found = found_q;
	assign pick.idx   = idx_q;
	assign pick.prio  = prio_q;

endmodule
`default_nettype wire
